@@ rtl/core/lmhts_pkg.sv @@
// Package for the layer maximum-hit track seeding block.
// Holds the sizing constants, codes, controller state type and the command/status structs.
// No dependencies; every other file of the block but lmhts_ram imports it.
package lmhts_pkg;

	// Array sizes and fixed-point scale.
	localparam int NUM_LAYERS   = 14;
	localparam int NUM_CHANNELS = 1024;
	localparam int FRAC_BITS    = 4;

	// Field widths of the input items, results and registers.
	localparam int OP_W    = 2;
	localparam int CH_W    = 10;
	localparam int LAYER_W = 4;
	localparam int BAR_W   = 6;
	localparam int ADC_W   = 16;
	localparam int DYN_W   = 4;
	localparam int PED_W   = 20;
	localparam int MUL_W   = 4;
	localparam int THR_W   = 16;
	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 16;

	// Derived widths.
	localparam int LY_AW  = $clog2(NUM_LAYERS);
	localparam int CH_AW  = $clog2(NUM_CHANNELS);
	localparam int AMP_W  = ADC_W + FRAC_BITS;
	localparam int PROD_W = PED_W + MUL_W;
	localparam int LIM_W  = PROD_W + 1;

	// Item opcodes.
	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_HIT  = 2'd1;
	localparam logic [OP_W-1:0] OP_END  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_AW-1:0] REG_DYNODE = 3'd0;
	localparam logic [CFG_AW-1:0] REG_SIDE   = 3'd1;
	localparam logic [CFG_AW-1:0] REG_SIGMUL = 3'd2;
	localparam logic [CFG_AW-1:0] REG_OUTER  = 3'd3;
	localparam logic [CFG_AW-1:0] REG_INNER  = 3'd4;

	// Configuration reset values.
	localparam logic [DYN_W-1:0] DYNODE_RST = 4'd8;
	localparam logic             SIDE_RST   = 1'b0;
	localparam logic [MUL_W-1:0] SIGMUL_RST = 4'd3;
	localparam logic [THR_W-1:0] OUTER_RST  = 16'd150;
	localparam logic [THR_W-1:0] INNER_RST  = 16'd50;

	// Layers that take part in the track coincidence.
	localparam int LAYER_OUTER_LO = 0;
	localparam int LAYER_OUTER_HI = 13;
	localparam int LAYER_INNER_LO = 1;
	localparam int LAYER_INNER_HI = 12;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_EMIT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             ped_wr;
		logic             hit_cap;
		logic             mul_en;
		logic             upd_en;
		logic             flag_cap;
		logic             emit_en;
		logic             clr_layers;
		logic [LY_AW-1:0] emit_layer;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

@@ rtl/core/lmhts_in_if.sv @@
// Input item channel: valid/ready handshake with the load, hit and end-of-event payload.
// Depends on lmhts_pkg for field widths.
interface lmhts_in_if import lmhts_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [CH_W-1:0]     channel;
	logic [LAYER_W-1:0]  layer;
	logic [BAR_W-1:0]    bar;
	logic [ADC_W-1:0]    adc;
	logic [DYN_W-1:0]    dynode;
	logic                side;
	logic [PED_W-1:0]    ped_mean;
	logic [PED_W-1:0]    ped_sigma;

	modport source (output valid, opcode, channel, layer, bar, adc, dynode, side,
		ped_mean, ped_sigma, input ready);
	modport sink (input valid, opcode, channel, layer, bar, adc, dynode, side,
		ped_mean, ped_sigma, output ready);
endinterface

@@ rtl/core/lmhts_out_if.sv @@
// Result channel: valid/ready handshake with one per-layer seeding result.
// Depends on lmhts_pkg for field widths.
interface lmhts_out_if import lmhts_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LAYER_W-1:0] layer_index;
	logic [BAR_W-1:0]   best_bar;
	logic               track_found;
	logic               last;

	modport source (output valid, layer_index, best_bar, track_found, last, input ready);
	modport sink (input valid, layer_index, best_bar, track_found, last, output ready);
endinterface

@@ rtl/core/lmhts_cfg_if.sv @@
// Configuration write channel: valid/ready handshake carrying a register index and data.
// Depends on lmhts_pkg for field widths.
interface lmhts_cfg_if import lmhts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CFG_AW-1:0] reg_index;
	logic [CFG_DW-1:0] reg_data;

	modport source (output valid, reg_index, reg_data, input ready);
	modport sink (input valid, reg_index, reg_data, output ready);
endinterface

@@ rtl/core/lmhts_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No package dependency; width and depth come from parameters.
module lmhts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/lmhts_ctrl.sv @@
// Controller state machine: sequences pedestal loads, hit checks and result emission.
// Depends on lmhts_pkg for the state type and the command/status structs.
module lmhts_ctrl import lmhts_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic [OP_W-1:0] item_opcode,
	input  sts_t            sts,
	output logic            item_ready,
	output cmd_t            cmd
);

	ctrl_state_t      state_q, state_d;
	logic [LY_AW-1:0] cnt_q, cnt_d;

	// State and emission counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		item_ready = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					unique case (item_opcode)
						OP_LOAD: begin
							cmd.ped_wr = 1'b1;
						end
						OP_HIT: begin
							cmd.hit_cap = 1'b1;
							state_d     = ST_READ;
						end
						OP_END: begin
							cmd.flag_cap = 1'b1;
							cnt_d        = '0;
							state_d      = ST_EMIT;
						end
						default: begin
							// Unused opcode: the transfer is taken and dropped.
						end
					endcase
				end
			end
			ST_READ: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.upd_en = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_en    = 1'b1;
					cmd.emit_layer = cnt_q;
					if (cnt_q == LY_AW'(NUM_LAYERS - 1)) begin
						cmd.clr_layers = 1'b1;
						state_d        = ST_IDLE;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/lmhts_dp.sv @@
// Datapath: configuration registers, pedestal memory, hit threshold check,
// per-layer maximum store, track flag and the result output register.
// Depends on lmhts_pkg, the three channel interfaces and lmhts_ram.
module lmhts_dp import lmhts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lmhts_in_if.sink    item,
	lmhts_out_if.source res,
	lmhts_cfg_if.sink   cfg,
	input  cmd_t        cmd,
	output sts_t        sts
);

	// Configuration registers.
	logic [DYN_W-1:0] dyn_sel_q;
	logic             side_sel_q;
	logic [MUL_W-1:0] sig_mul_q;
	logic [THR_W-1:0] outer_thr_q;
	logic [THR_W-1:0] inner_thr_q;

	// Pedestal memory signals.
	logic                 ch_ok;
	logic [CH_AW-1:0]     ch_addr;
	logic [2*PED_W-1:0]   ped_rdata;

	// Hit sequencing registers.
	logic                 hit_ok_q;
	logic [LY_AW-1:0]     hit_layer_q;
	logic [BAR_W-1:0]     hit_bar_q;
	logic [AMP_W-1:0]     scaled_q;
	logic [PROD_W-1:0]    prod_q;
	logic [PED_W-1:0]     mean_q;

	// Threshold check.
	logic [LIM_W-1:0]     limit;
	logic [LIM_W-1:0]     amp_full;
	logic [AMP_W-1:0]     amp;
	logic                 pass;
	logic                 upd;

	// Per-layer store.
	logic [AMP_W-1:0]     lay_amp_q [NUM_LAYERS];
	logic [BAR_W-1:0]     lay_bar_q [NUM_LAYERS];
	logic [NUM_LAYERS-1:0] lay_vld_q;
	logic [AMP_W-1:0]     eff_amp [NUM_LAYERS];
	logic [LY_AW-1:0]     rd_layer;
	logic [AMP_W-1:0]     cur_amp;
	logic [BAR_W-1:0]     cur_bar;

	// Track flag.
	logic [AMP_W-1:0]     outer_lim;
	logic [AMP_W-1:0]     inner_lim;
	logic                 track_q;

	// Output register.
	logic                 out_valid_q;
	logic [LAYER_W-1:0]   out_layer_q;
	logic [BAR_W-1:0]     out_bar_q;
	logic                 out_track_q;
	logic                 out_last_q;

	// Configuration writes; indexes beyond the register list are ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dyn_sel_q   <= DYNODE_RST;
			side_sel_q  <= SIDE_RST;
			sig_mul_q   <= SIGMUL_RST;
			outer_thr_q <= OUTER_RST;
			inner_thr_q <= INNER_RST;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				REG_DYNODE: dyn_sel_q   <= cfg.reg_data[DYN_W-1:0];
				REG_SIDE:   side_sel_q  <= cfg.reg_data[0];
				REG_SIGMUL: sig_mul_q   <= cfg.reg_data[MUL_W-1:0];
				REG_OUTER:  outer_thr_q <= cfg.reg_data[THR_W-1:0];
				REG_INNER:  inner_thr_q <= cfg.reg_data[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Pedestal memory holds {mean, sigma}; written on load, read on hit.
	assign ch_ok   = int'(item.channel) < NUM_CHANNELS;
	assign ch_addr = CH_AW'(item.channel);

	lmhts_ram #(
		.WIDTH (2 * PED_W),
		.DEPTH (NUM_CHANNELS)
	) u_ped_ram (
		.clk   (clk),
		.we    (cmd.ped_wr && ch_ok),
		.waddr (ch_addr),
		.wdata ({item.ped_mean, item.ped_sigma}),
		.re    (cmd.hit_cap),
		.raddr (ch_addr),
		.rdata (ped_rdata)
	);

	// Hit capture: source selection and range checks, count lifted to the pedestal scale.
	always_ff @(posedge clk) begin
		if (cmd.hit_cap) begin
			hit_ok_q    <= (item.dynode == dyn_sel_q) && (item.side == side_sel_q) &&
				ch_ok && (int'(item.layer) < NUM_LAYERS);
			hit_layer_q <= LY_AW'(item.layer);
			hit_bar_q   <= item.bar;
			scaled_q    <= AMP_W'(item.adc) << FRAC_BITS;
		end
	end

	// Sigma multiple, registered before the limit add.
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(sig_mul_q) * PROD_W'(ped_rdata[PED_W-1:0]);
			mean_q <= ped_rdata[2*PED_W-1:PED_W];
		end
	end

	// Threshold check and amplitude above the pedestal mean.
	assign limit    = LIM_W'(mean_q) + LIM_W'(prod_q);
	assign pass     = LIM_W'(scaled_q) > limit;
	assign amp_full = LIM_W'(scaled_q) - LIM_W'(mean_q);
	assign amp      = amp_full[AMP_W-1:0];

	// Entries without a kept hit read as zero.
	always_comb begin
		for (int i = 0; i < NUM_LAYERS; i++) begin
			eff_amp[i] = lay_vld_q[i] ? lay_amp_q[i] : '0;
		end
	end

	// One read address: the emitted layer during emission, else the hit's layer.
	assign rd_layer = cmd.emit_en ? cmd.emit_layer : hit_layer_q;
	assign cur_amp  = eff_amp[rd_layer];
	assign cur_bar  = lay_vld_q[rd_layer] ? lay_bar_q[rd_layer] : '0;

	// A strictly larger amplitude replaces the stored one, so ties keep the earlier hit.
	assign upd = cmd.upd_en && hit_ok_q && pass && (amp > cur_amp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lay_vld_q <= '0;
		end else if (cmd.clr_layers) begin
			lay_vld_q <= '0;
		end else if (upd) begin
			lay_vld_q[hit_layer_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			lay_amp_q[hit_layer_q] <= amp;
			lay_bar_q[hit_layer_q] <= hit_bar_q;
		end
	end

	// Track coincidence, sampled when the end-of-event item is taken.
	assign outer_lim = AMP_W'(outer_thr_q) << FRAC_BITS;
	assign inner_lim = AMP_W'(inner_thr_q) << FRAC_BITS;

	always_ff @(posedge clk) begin
		if (cmd.flag_cap) begin
			track_q <= (eff_amp[LAYER_OUTER_LO] > outer_lim) &&
				(eff_amp[LAYER_OUTER_HI] > outer_lim) &&
				((eff_amp[LAYER_INNER_LO] > inner_lim) ||
				(eff_amp[LAYER_INNER_HI] > inner_lim));
		end
	end

	// Output register: loaded when empty or when its result is transferred.
	assign sts.out_free = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_en) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_en) begin
			out_layer_q <= LAYER_W'(cmd.emit_layer);
			out_bar_q   <= cur_bar;
			out_track_q <= track_q;
			out_last_q  <= cmd.emit_layer == LY_AW'(NUM_LAYERS - 1);
		end
	end

	assign res.valid       = out_valid_q;
	assign res.layer_index = out_layer_q;
	assign res.best_bar    = out_bar_q;
	assign res.track_found = out_track_q;
	assign res.last        = out_last_q;

endmodule

@@ rtl/core/layer_max_hit_track_seed.sv @@
// Layer maximum-hit track seeding. A load is written to the pedestal memory when taken; a hit
// steps through transfer and memory read, sigma product, then threshold check and layer
// update; no new item is taken meanwhile. Throughput: one load per cycle when idle; after an
// end-of-event item, one result per cycle for the 14 layers, paced by the result output register.
// Reset sets the configuration registers to their defaults and empties the layer stores;
// the pedestal memory is undefined until loaded and gets no clearing pass.
module layer_max_hit_track_seed import lmhts_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	lmhts_in_if.sink    item_in,
	lmhts_out_if.source result_out,
	lmhts_cfg_if.sink   cfg
);

	cmd_t cmd;
	sts_t sts;
	logic item_ready;

	// Input transfers are taken only when the controller is idle.
	assign item_in.ready = item_ready;

	// Sequencer.
	lmhts_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_in.valid),
		.item_opcode (item_in.opcode),
		.sts         (sts),
		.item_ready  (item_ready),
		.cmd         (cmd)
	);

	// Datapath.
	lmhts_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_in),
		.res    (result_out),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

@@ rtl/core/lmhts_checker.sv @@
// Port-level checker for the track seeding block, attached to the top level by bind.
// Depends on lmhts_pkg for opcodes, widths and the layer count.
module lmhts_checker import lmhts_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [OP_W-1:0]    in_opcode,
	input logic               out_valid,
	input logic               out_ready,
	input logic [LAYER_W-1:0] out_layer_index,
	input logic [BAR_W-1:0]   out_best_bar,
	input logic               out_track_found,
	input logic               out_last
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_layer_index) &&
		$stable(out_best_bar) && $stable(out_track_found) && $stable(out_last))
		else $error("stalled result changed");

	// The last result of an event describes the highest layer.
	a_last_layer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |-> out_layer_index == LAYER_W'(NUM_LAYERS - 1))
		else $error("last flag on wrong layer");

	// A hit or end-of-event transfer keeps the input closed for the next cycle.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_opcode == OP_HIT || in_opcode == OP_END) |=> !in_ready)
		else $error("input taken while busy");

	// Results of an event follow each other without a gap, so valid only rises on layer 0.
	a_first_layer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> out_layer_index == '0)
		else $error("result sequence did not start at layer zero");

endmodule

bind layer_max_hit_track_seed lmhts_checker u_lmhts_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (item_in.valid),
	.in_ready        (item_in.ready),
	.in_opcode       (item_in.opcode),
	.out_valid       (result_out.valid),
	.out_ready       (result_out.ready),
	.out_layer_index (result_out.layer_index),
	.out_best_bar    (result_out.best_bar),
	.out_track_found (result_out.track_found),
	.out_last        (result_out.last)
);
